### rtl/tpef_pkg.sv
`default_nettype none
package tpef_pkg;

  typedef enum logic [2:0] {
    CatPassed   = 3'd0,
    CatExempt   = 3'd1,
    CatShort    = 3'd2,
    CatEntropy  = 3'd3,
    CatProtocol = 3'd4,
    CatPort     = 3'd5
  } category_e;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeArp  = 16'h0806;
  localparam logic [15:0] FixedCheckPort = 16'd9001;
  localparam logic [15:0] FixedPassPort  = 16'd22;

  localparam logic [2:0] CfgExempt = 3'd0;
  localparam logic [2:0] CfgPortA  = 3'd1;
  localparam logic [2:0] CfgPortB  = 3'd2;
  localparam logic [2:0] CfgPortC  = 3'd3;
  localparam logic [2:0] CfgSrc    = 3'd4;
  localparam logic [2:0] CfgHs     = 3'd5;
  localparam logic [2:0] CfgAuth   = 3'd6;
  localparam logic [2:0] CfgMinPl  = 3'd7;

  // Per-frame summary handed from the parser to the verdict engine
  typedef struct packed {
    logic         final_cat;   // verdict needs no table access
    logic [2:0]   cat;
    logic         pass;
    logic [13:0]  plen;
    logic [8:0]   uniq;
    logic [63:0]  key;
  } frame_t;

  typedef struct packed {
    logic [15:0] exempt_port;
    logic [15:0] port_a;
    logic [15:0] port_b;
    logic [15:0] port_c;
    logic [15:0] src_port;
    logic [8:0]  hs_thr;
    logic [8:0]  auth_thr;
    logic [13:0] min_pl;
  } cfg_t;

endpackage
`default_nettype wire

### rtl/tpef_parse.sv
`default_nettype none
// Front end: header capture, payload bitmap, popcount and classification.
module tpef_parse #(
  parameter int ANALYZE_LIMIT = 1500,
  parameter int FRAME_LIMIT   = 16384
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tpef_pkg::cfg_t  cfg_i,
  input  wire logic            valid_i,
  output logic                 stall_o,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  output logic                 fr_valid_o,
  input  wire logic            fr_ready_i,
  output tpef_pkg::frame_t     fr_o
);
  localparam int PW = $clog2(FRAME_LIMIT + 1);

  logic [PW-1:0] pos_q;
  logic [15:0] et_q, sp_q, dp_q;
  logic [7:0]  vl_q, pr_q;
  logic [31:0] sa_q;
  logic [3:0]  off_q;
  logic [255:0] seen_q;

  // popcount sequencer: 8 words, one per cycle
  logic        busy_q;
  logic [2:0]  word_q;
  logic [8:0]  cnt_q;
  logic [255:0] snap_q;
  tpef_pkg::frame_t pend_q;
  logic        out_q;
  logic        needcnt_q;

  logic acc;
  assign stall_o = busy_q;
  assign acc = valid_i && !busy_q;

  logic [PW-1:0] t, ps, p;
  logic inside_pl;
  assign p  = pos_q;
  assign t  = PW'(14) + PW'({vl_q[3:0], 2'b00});
  assign ps = t + PW'({off_q, 2'b00});
  assign inside_pl = (off_q >= 4'd5) && (p >= ps) && ((p - ps) < PW'(ANALYZE_LIMIT));

  // Header fields as they stand after this byte
  logic [PW-1:0] len;
  logic [15:0] et_n, sp_n, dp_n;
  logic [7:0]  vl_n, pr_n;
  logic [3:0]  off_n;
  logic [31:0] sa_n;
  logic [255:0] seen_n;
  logic live;
  logic [PW-1:0] tn;
  always_comb begin
    live = (p < PW'(FRAME_LIMIT));
    et_n = et_q; vl_n = vl_q; pr_n = pr_q; sa_n = sa_q; sp_n = sp_q; dp_n = dp_q;
    off_n = off_q; seen_n = seen_q;
    len = live ? p + PW'(1) : p;
    if (live) begin
      if (p == PW'(12) || p == PW'(13)) et_n = {et_q[7:0], byte_i};
      if (p == PW'(14)) vl_n = byte_i;
      if (p == PW'(23)) pr_n = byte_i;
      if (p >= PW'(26) && p <= PW'(29)) sa_n = {sa_q[23:0], byte_i};
      if (p == t || p == t + PW'(1)) sp_n = {sp_q[7:0], byte_i};
      if (p == t + PW'(2) || p == t + PW'(3)) dp_n = {dp_q[7:0], byte_i};
      if (p == t + PW'(12)) off_n = byte_i[7:4];
      if (inside_pl) seen_n[byte_i] = 1'b1;
    end
    tn = PW'(14) + PW'({vl_n[3:0], 2'b00});
  end

  // Classification of the finished frame
  tpef_pkg::frame_t cls;
  logic [PW-1:0] psn, plen_w;
  logic allowed;
  always_comb begin
    cls = '0;
    cls.final_cat = 1'b1;
    cls.cat = tpef_pkg::CatProtocol;
    cls.key = {sa_n, sp_n, dp_n};
    psn = tn + PW'({off_n, 2'b00});
    plen_w = len - psn;
    allowed = (sp_n == tpef_pkg::FixedCheckPort) || (dp_n == tpef_pkg::FixedCheckPort)
      || (cfg_i.port_a != 0 && (sp_n == cfg_i.port_a || dp_n == cfg_i.port_a))
      || (cfg_i.port_b != 0 && (sp_n == cfg_i.port_b || dp_n == cfg_i.port_b))
      || (cfg_i.port_c != 0 && (sp_n == cfg_i.port_c || dp_n == cfg_i.port_c))
      || (cfg_i.src_port != 0 && sp_n == cfg_i.src_port);
    priority if (len < PW'(14)) begin
    end else if (et_n == tpef_pkg::EtypeArp) begin
      cls.pass = 1'b1; cls.cat = tpef_pkg::CatPassed;
    end else if (et_n != tpef_pkg::EtypeIpv4 || len < PW'(34)) begin
    end else if (vl_n[7:4] != 4'd4 || pr_n != 8'd6 || vl_n[3:0] < 4'd5) begin
    end else if (len < tn + PW'(20)) begin
    end else if (sp_n == tpef_pkg::FixedPassPort || dp_n == tpef_pkg::FixedPassPort) begin
      cls.pass = 1'b1; cls.cat = tpef_pkg::CatPassed;
    end else if (cfg_i.exempt_port != 0 &&
                 (sp_n == cfg_i.exempt_port || dp_n == cfg_i.exempt_port)) begin
      cls.pass = 1'b1; cls.cat = tpef_pkg::CatExempt;
    end else if (!allowed) begin
      cls.cat = tpef_pkg::CatPort;
    end else if (off_n < 4'd5) begin
    end else if (psn >= len) begin
      cls.pass = 1'b1; cls.cat = tpef_pkg::CatShort;
    end else begin
      cls.plen = (plen_w > PW'(16383)) ? 14'h3FFF : 14'(plen_w);
      if (plen_w < PW'(cfg_i.min_pl)) begin
        cls.pass = 1'b1; cls.cat = tpef_pkg::CatShort;
      end else begin
        cls.final_cat = 1'b0;
      end
    end
  end

  // Capture bytes, snapshot the bitmap at the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; et_q <= '0; vl_q <= '0; pr_q <= '0; sa_q <= '0;
      sp_q <= '0; dp_q <= '0; off_q <= '0; seen_q <= '0;
      busy_q <= 1'b0; word_q <= '0; cnt_q <= '0; out_q <= 1'b0; needcnt_q <= 1'b0;
    end else begin
      if (acc) begin
        if (last_i) begin
          pos_q <= '0; et_q <= '0; vl_q <= '0; pr_q <= '0; sa_q <= '0;
          sp_q <= '0; dp_q <= '0; off_q <= '0; seen_q <= '0;
          pend_q <= cls; snap_q <= seen_n; busy_q <= 1'b1;
          needcnt_q <= !cls.final_cat; word_q <= '0; cnt_q <= '0; out_q <= 1'b0;
        end else begin
          pos_q <= len; et_q <= et_n; vl_q <= vl_n; pr_q <= pr_n; sa_q <= sa_n;
          sp_q <= sp_n; dp_q <= dp_n; off_q <= off_n; seen_q <= seen_n;
        end
      end else if (busy_q) begin
        if (out_q) begin
          if (fr_ready_i) begin
            busy_q <= 1'b0; out_q <= 1'b0;
          end
        end else if (needcnt_q) begin
          cnt_q <= cnt_q + 9'($countones(snap_q[word_q*32 +: 32]));
          word_q <= word_q + 3'd1;
          if (word_q == 3'd7) out_q <= 1'b1;
        end else begin
          out_q <= 1'b1;
        end
      end
    end
  end

  assign fr_valid_o = out_q;
  always_comb begin
    fr_o = pend_q;
    fr_o.uniq = cnt_q;
  end

  a_nobusy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q |-> busy_q) else $error("output without busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_q && !fr_ready_i) |=> out_q) else $error("frame lost");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(acc && last_i)) else $error("busy without frame end");
endmodule
`default_nettype wire

### rtl/tpef_fifo.sv
`default_nettype none
// Two-entry queue between parser and verdict engine.
module tpef_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire tpef_pkg::frame_t wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output tpef_pkg::frame_t      rd_data_o
);
  tpef_pkg::frame_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;
  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) begin
        mem_q[wp_q] <= wr_data_i; wp_q <= ~wp_q;
      end
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("fifo count overflow");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !rd) |=> cnt_q == 2'd2) else $error("fifo lost entry");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wp_q == rp_q)) else $error("fifo pointers");
endmodule
`default_nettype wire

### rtl/tpef_verdict.sv
`default_nettype none
// Generic simple dual-port RAM with registered read.
module tpef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read one word a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule

// Back end: flow table search (one entry a cycle), threshold and verdict.
module tpef_verdict #(
  parameter int TABLE_ENTRIES   = 64,
  parameter int HANDSHAKE_LIMIT = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tpef_pkg::cfg_t   cfg_i,
  input  wire logic             fr_valid_i,
  output logic                  fr_ready_o,
  input  wire tpef_pkg::frame_t fr_i,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output logic                  pass_o,
  output logic [2:0]            cat_o,
  output logic [8:0]            uniq_o,
  output logic [13:0]           plen_o
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {Idle, Search, Write, Done} state_e;
  state_e st_q;

  logic [CW-1:0] fill_q, idx_q;
  logic [IW-1:0] widx_q;
  logic        chk_q;
  logic [4:0]  prior_q;
  logic        hit_q;
  tpef_pkg::frame_t f_q;
  logic [17:0] cap_q;
  logic        ov_q;
  logic        pass_q;
  logic [2:0]  cat_q;
  logic [8:0]  uniq_q;
  logic [13:0] plen_q;

  // entries fill from slot 0 and never leave, so a fill count stands for valid bits
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [68:0]   ram_wdata, ram_rdata;
  logic [63:0]   rd_key;
  logic [4:0]    rd_pkt;
  assign rd_key = ram_rdata[68:5];
  assign rd_pkt = ram_rdata[4:0];

  tpef_ram #(.WIDTH(69), .DEPTH(TABLE_ENTRIES), .AW(IW)) u_flow_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(idx_q[IW-1:0]), .rdata_o(ram_rdata));

  // Bump a known flow below the handshake limit, or insert a new one while the table has room
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = fill_q[IW-1:0];
    ram_wdata = {f_q.key, 5'd1};
    if (st_q == Write) begin
      if (hit_q) begin
        ram_we = prior_q < 5'(HANDSHAKE_LIMIT);
        ram_waddr = widx_q;
        ram_wdata = {f_q.key, prior_q + 5'd1};
      end else begin
        ram_we = fill_q < CW'(TABLE_ENTRIES);
      end
    end
  end

  assign fr_ready_o = (st_q == Idle) && !ov_q;
  assign valid_o = ov_q;
  assign pass_o = pass_q; assign cat_o = cat_q; assign uniq_o = uniq_q; assign plen_o = plen_q;

  // The count meets floor(7*plen/10) exactly when 10*(count+1) exceeds 7*plen
  logic [8:0]  thr;
  logic [17:0] uniq_x10;
  logic        pass_w;
  always_comb begin
    thr = (prior_q < 5'(HANDSHAKE_LIMIT)) ? cfg_i.hs_thr : cfg_i.auth_thr;
    uniq_x10 = 18'(f_q.uniq) * 18'd10 + 18'd10;
    pass_w = (f_q.uniq >= thr) || (uniq_x10 > cap_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= Idle; fill_q <= '0; idx_q <= '0; chk_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (ov_q && !stall_i) ov_q <= 1'b0;
      unique case (st_q)
        Idle: begin
          if (fr_valid_i && !ov_q) begin
            f_q <= fr_i; idx_q <= '0; chk_q <= 1'b0; hit_q <= 1'b0; prior_q <= '0;
            if (fr_i.final_cat) begin
              pass_q <= fr_i.pass; cat_q <= fr_i.cat; uniq_q <= '0;
              plen_q <= fr_i.plen; ov_q <= 1'b1;
            end else begin
              st_q <= Search;
            end
          end
        end
        // Read data is registered and belongs to the previous value of the address
        Search: begin
          if (chk_q && rd_key == f_q.key) begin
            hit_q <= 1'b1; prior_q <= rd_pkt; widx_q <= IW'(idx_q - CW'(1));
            st_q <= Write;
          end else if (idx_q == fill_q) begin
            st_q <= Write;
          end else begin
            idx_q <= idx_q + CW'(1);
            chk_q <= 1'b1;
          end
        end
        Write: begin
          if (!hit_q && fill_q < CW'(TABLE_ENTRIES)) fill_q <= fill_q + CW'(1);
          cap_q <= {4'd0, f_q.plen} * 18'd7;
          st_q <= Done;
        end
        Done: begin
          if (!ov_q) begin
            uniq_q <= f_q.uniq; plen_q <= f_q.plen;
            pass_q <= pass_w;
            cat_q <= pass_w ? tpef_pkg::CatPassed : tpef_pkg::CatEntropy;
            ov_q <= 1'b1; st_q <= Idle;
          end
        end
        default: st_q <= Idle;
      endcase
    end
  end

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(TABLE_ENTRIES)) else $error("fill overflow");
  a_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == Search) |-> idx_q <= fill_q) else $error("search beyond fill");
  a_outhold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && stall_i) |=> ov_q && $stable(cat_q)) else $error("result changed");
endmodule
`default_nettype wire

### rtl/tcp_port_entropy_packet_filter.sv
// Path: the parser registers a summary at the last byte, runs the popcount when an
//   entropy check is needed, then queues it for the flow search and the verdict.
// Throughput: one byte per cycle within a frame; after the last byte the input
//   stalls until the parser, popcount included, has handed the frame to the queue.
// Reset: asynchronous active low; configuration returns to defaults, the flow
//   table empties at once (fill count), no clearing pass.
`default_nettype none
module tcp_port_entropy_packet_filter #(
  parameter int TABLE_ENTRIES   = 64,
  parameter int ANALYZE_LIMIT   = 1500,
  parameter int HANDSHAKE_LIMIT = 20,
  parameter int FRAME_LIMIT     = 16384
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        last_byte_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic             pass_frame_o,
  output logic [2:0]       category_o,
  output logic [8:0]       unique_count_o,
  output logic [13:0]      payload_length_o
);
  tpef_pkg::cfg_t cfg_q;
  assign cfg_ready_o = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{exempt_port: '0, port_a: '0, port_b: '0, port_c: '0, src_port: '0,
                 hs_thr: 9'd80, auth_thr: 9'd85, min_pl: 14'd128};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tpef_pkg::CfgExempt: cfg_q.exempt_port <= cfg_data_i;
        tpef_pkg::CfgPortA:  cfg_q.port_a <= cfg_data_i;
        tpef_pkg::CfgPortB:  cfg_q.port_b <= cfg_data_i;
        tpef_pkg::CfgPortC:  cfg_q.port_c <= cfg_data_i;
        tpef_pkg::CfgSrc:    cfg_q.src_port <= cfg_data_i;
        tpef_pkg::CfgHs:     cfg_q.hs_thr <= cfg_data_i[8:0];
        tpef_pkg::CfgAuth:   cfg_q.auth_thr <= cfg_data_i[8:0];
        tpef_pkg::CfgMinPl:  cfg_q.min_pl <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  logic fv, fr, qv, qr;
  tpef_pkg::frame_t fd, qd;

  tpef_parse #(.ANALYZE_LIMIT(ANALYZE_LIMIT), .FRAME_LIMIT(FRAME_LIMIT)) u_parse (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i, .stall_o,
    .byte_i(frame_byte_i), .last_i(last_byte_i),
    .fr_valid_o(fv), .fr_ready_i(fr), .fr_o(fd));

  tpef_fifo u_fifo (.clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fd),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qd));

  tpef_verdict #(.TABLE_ENTRIES(TABLE_ENTRIES), .HANDSHAKE_LIMIT(HANDSHAKE_LIMIT)) u_verdict (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .fr_valid_i(qv), .fr_ready_o(qr), .fr_i(qd),
    .valid_o, .stall_i, .pass_o(pass_frame_o), .cat_o(category_o),
    .uniq_o(unique_count_o), .plen_o(payload_length_o));
endmodule
`default_nettype wire
